FILE: hdl/brle8_pkg.sv
// Shared types, constants and codes for the RLE8 stream decoder.
package brle8_pkg;

   localparam int BRLE8_OUT_LANES_DEF = 8;
   localparam int MAX_WORDS           = 32;
   localparam int CAP_W               = 31;
   localparam int RUN_W               = 9;

   localparam logic [CAP_W-1:0] CAP_RESET = 31'h4000_0000;
   localparam logic [CAP_W-1:0] BW_MAX    = 31'h7FFF_FFFF;

   // parse phases
   localparam logic [1:0] PH_COUNT   = 2'd0;
   localparam logic [1:0] PH_SECOND  = 2'd1;
   localparam logic [1:0] PH_LITERAL = 2'd2;
   localparam logic [1:0] PH_PAD     = 2'd3;

   // escape codes after a zero count
   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOI   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;

   // end causes
   localparam logic [1:0] CAUSE_END_CODE = 2'd0;
   localparam logic [1:0] CAUSE_CAPACITY = 2'd1;
   localparam logic [1:0] CAUSE_SOURCE   = 2'd2;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] pixel_bytes;
      logic [3:0]  byte_count;
      logic        image_end;
      logic [1:0]  end_cause;
   } rsp_type;

   typedef struct packed {
      logic take_item;
      logic load_word;
   } cmd_type;

   typedef struct packed {
      logic emits;
      logic last_word;
      logic slot_free;
   } status_type;

endpackage

FILE: hdl/brle8_ctrl.sv
// Controller: sequences byte intake and result word emission.
module brle8_ctrl
   import brle8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.take_item = 1'b0;
      cmd.load_word = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take_item = req_valid;
            if (req_valid && status.emits) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.load_word = status.slot_free;
            if (status.slot_free && status.last_word) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/brle8_dp.sv
// Datapath: parse state, byte counter, capacity register and output word register.
module brle8_dp
   import brle8_pkg::*;
#(
   parameter int OUT_LANES = BRLE8_OUT_LANES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  logic             csr_write,
   input  logic [CAP_W-1:0] csr_data,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  cmd_type          cmd,
   output status_type       status
);

   localparam int                WIDX_W    = $clog2(MAX_WORDS);
   localparam logic [RUN_W-1:0]  LANES_RUN = RUN_W'(OUT_LANES);
   localparam logic [3:0]        LANES_CNT = 4'(OUT_LANES);

   // per-image parse state
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       held_ff, held_in;
   logic [7:0]       lit_ff, lit_in;
   logic             skip_ff, skip_in;
   logic [1:0]       line_ff, line_in;
   logic [CAP_W-1:0] bw_ff, bw_in;
   logic             done_ff, done_in;
   logic [CAP_W-1:0] cap_ff;

   // emission state
   logic [RUN_W-1:0]  left_ff;
   logic [7:0]        val_ff;
   logic [WIDX_W-1:0] widx_ff;
   logic              endf_ff;
   logic [1:0]        cause_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // step results
   logic [RUN_W-1:0] n_w;
   logic [7:0]       val_w;
   logic             ended_w;
   logic [1:0]       cause_w;
   logic             completed_w;
   logic [7:0]       lit_dec;
   logic [1:0]       pad_w;
   logic [CAP_W:0]   bw_sum;
   logic [CAP_W-1:0] bw_sat;

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      lit_in      = lit_ff;
      skip_in     = skip_ff;
      line_in     = line_ff;
      done_in     = done_ff;
      n_w         = '0;
      val_w       = '0;
      ended_w     = 1'b0;
      cause_w     = CAUSE_END_CODE;
      completed_w = 1'b0;
      lit_dec     = (lit_ff != 8'd0) ? lit_ff - 8'd1 : 8'd0;
      // zero bytes still needed to reach a multiple of four
      pad_w       = 2'd0 - line_ff;

      if (!done_ff) begin
         unique case (phase_ff)
            PH_SECOND: begin
               if (held_ff != 8'd0) begin
                  n_w         = RUN_W'(held_ff);
                  val_w       = req_data.code_byte;
                  line_in     = line_ff + held_ff[1:0];
                  completed_w = 1'b1;
               end else if (req_data.code_byte > ESC_DELTA) begin
                  lit_in   = req_data.code_byte;
                  skip_in  = req_data.code_byte[0];
                  phase_in = PH_LITERAL;
               end else if (req_data.code_byte == ESC_EOL) begin
                  // pad the line with zeros to a multiple of four
                  n_w         = RUN_W'(pad_w);
                  line_in     = 2'd0;
                  completed_w = 1'b1;
               end else if (req_data.code_byte == ESC_EOI) begin
                  ended_w = 1'b1;
                  cause_w = CAUSE_END_CODE;
               end else begin
                  completed_w = 1'b1;
               end
            end
            PH_LITERAL: begin
               n_w     = RUN_W'(1);
               val_w   = req_data.code_byte;
               line_in = line_ff + 2'd1;
               lit_in  = lit_dec;
               if (lit_dec == 8'd0) begin
                  if (skip_ff) begin
                     phase_in = PH_PAD;
                  end else begin
                     completed_w = 1'b1;
                  end
               end
            end
            PH_PAD: completed_w = 1'b1;
            default: begin
               if (bw_ff >= cap_ff) begin
                  ended_w = 1'b1;
                  cause_w = CAUSE_CAPACITY;
               end else begin
                  held_in  = req_data.code_byte;
                  phase_in = PH_SECOND;
               end
            end
         endcase
      end

      if (completed_w) begin
         phase_in = PH_COUNT;
         held_in  = '0;
         lit_in   = '0;
         skip_in  = 1'b0;
      end

      bw_sum = {1'b0, bw_ff} + (CAP_W+1)'(n_w);
      bw_sat = bw_sum[CAP_W] ? BW_MAX : bw_sum[CAP_W-1:0];
      bw_in  = done_ff ? bw_ff : bw_sat;

      if (!done_ff && completed_w && !ended_w && (bw_sat >= cap_ff)) begin
         ended_w = 1'b1;
         cause_w = CAUSE_CAPACITY;
      end
      if (!done_ff && !ended_w && req_data.last_byte) begin
         ended_w = 1'b1;
         cause_w = CAUSE_SOURCE;
      end

      if (ended_w) begin
         done_in = 1'b1;
      end
      // a last-flagged byte returns the block to its per-image start
      if ((ended_w || done_ff) && req_data.last_byte) begin
         phase_in = PH_COUNT;
         held_in  = '0;
         lit_in   = '0;
         skip_in  = 1'b0;
         line_in  = '0;
         bw_in    = '0;
         done_in  = 1'b0;
      end
   end

   // next output word
   logic [3:0]  cnt_w;
   logic [63:0] word_w;
   logic        last_w;

   always_comb begin
      cnt_w  = (left_ff < LANES_RUN) ? left_ff[3:0] : LANES_CNT;
      last_w = (left_ff <= LANES_RUN) || (widx_ff == WIDX_W'(MAX_WORDS - 1));
      for (int i = 0; i < 8; i++) begin
         word_w[8*i +: 8] = (4'(i) < cnt_w) ? val_ff : 8'd0;
      end
   end

   assign status.emits     = (n_w != '0) || ended_w;
   assign status.last_word = last_w;
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT;
         held_ff      <= '0;
         lit_ff       <= '0;
         skip_ff      <= 1'b0;
         line_ff      <= '0;
         bw_ff        <= '0;
         done_ff      <= 1'b0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            cap_ff <= csr_data;
         end
         if (cmd.take_item) begin
            phase_ff <= phase_in;
            held_ff  <= held_in;
            lit_ff   <= lit_in;
            skip_ff  <= skip_in;
            line_ff  <= line_in;
            bw_ff    <= bw_in;
            done_ff  <= done_in;
         end
         if (cmd.load_word) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         left_ff  <= n_w;
         val_ff   <= val_w;
         widx_ff  <= '0;
         endf_ff  <= ended_w;
         cause_ff <= cause_w;
      end else if (cmd.load_word) begin
         left_ff <= left_ff - RUN_W'(cnt_w);
         widx_ff <= widx_ff + WIDX_W'(1);
      end
      if (cmd.load_word) begin
         rsp_ff.pixel_bytes <= word_w;
         rsp_ff.byte_count  <= cnt_w;
         rsp_ff.image_end   <= endf_ff && last_w;
         rsp_ff.end_cause   <= (endf_ff && last_w) ? cause_ff : CAUSE_END_CODE;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/bmp_rle8_stream_decoder_unit.sv
// Top level of the bitmap RLE8 stream decoder: controller plus datapath.
// Takes one compressed byte per transfer and returns decoded pixel bytes packed
// up to OUT_LANES per result word, first byte in bits 7:0. A byte causes k
// result words, k from 0 to 32 (a 255-byte fill run gives 32 words at eight
// lanes). The emission sequencer loads them one per cycle into the single
// output word register while it is free (rsp_stall holds it); the input is
// stalled while the words of a byte drain, and the next byte is taken while
// the last word still waits in that register.
// The output_capacity register is written through the csr channel (always
// ready); write it only while the block is idle. After an image ends, bytes
// are dropped until one flagged last, which readies the block for a new image.
module bmp_rle8_stream_decoder_unit
   import brle8_pkg::*;
#(
   parameter int OUT_LANES = BRLE8_OUT_LANES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // compressed byte input
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   // decoded result words
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   // output_capacity register write
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // register writes never wait
   assign csr_ready = 1'b1;

   // sequencer: take a byte, then load its result words one per unstalled cycle
   brle8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // parse state, counters and the output word register
   brle8_dp #(
      .OUT_LANES (OUT_LANES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: hdl/brle8_checker.sv
// Port-level checks for the RLE8 stream decoder, bound to the top level.
module brle8_checker
   import brle8_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // the end cause is zero on words that do not end the image
   a_cause_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.image_end |-> rsp_data.end_cause == CAUSE_END_CODE)
      else $error("end cause set without image end");

   // an empty word is only the end marker, with no lane data
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_count == 4'd0 |->
         rsp_data.image_end && rsp_data.pixel_bytes == 64'd0)
      else $error("empty result word that is not an image end");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs active after reset");

endmodule

bind bmp_rle8_stream_decoder_unit brle8_checker u_brle8_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: test/testbench.sv
// Self-checking testbench for the bitmap RLE8 stream decoder unit.
module testbench;
   import brle8_pkg::*;

   localparam int LANES        = BRLE8_OUT_LANES_DEF;
   // A byte drains at most MAX_WORDS result words; leave a margin on top.
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 50;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SHOWN_ERRORS = 10;

   // Zero count byte that opens an escape pair.
   localparam logic [7:0]       ESCAPE      = 8'd0;
   // Capacity with every bit below the top one set.
   localparam logic [CAP_W-1:0] CAP_ALL_LOW = 31'h3FFF_FFFF;

   typedef enum bit {ROW_BYTE, ROW_CAPACITY} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [CAP_W-1:0] value;
      logic             last;
      bit               typed;
      rsp_type          want;
   } stim_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data  = '0;

   // Decoder state as the testbench tracks it.
   logic [1:0]       parse_st;
   logic [7:0]       run_len;
   logic [7:0]       lit_left;
   logic             pad_due;
   logic [1:0]       line_ofs;
   logic [CAP_W-1:0] out_total;
   logic             img_over;
   logic [CAP_W-1:0] cap_limit;

   rsp_type      pending_words[$];
   rsp_type      fresh_words[$];
   stim_row_type stim_rows[$];

   int tx_idle_pct = 12;
   int rx_idle_pct = 48;
   int mismatches  = 0;
   int cycles      = 0;
   int counted     = 0;

   bmp_rle8_stream_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Stall the result channel at random, changing only on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
         $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
   endtask

   // Compare every result transfer with the oldest expected word.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch("word with nothing expected", '0, rsp_data.pixel_bytes);
         end else begin
            want = pending_words.pop_front();
            if (rsp_data.pixel_bytes !== want.pixel_bytes)
               report_mismatch("pixel_bytes", want.pixel_bytes, rsp_data.pixel_bytes);
            if (rsp_data.byte_count !== want.byte_count)
               report_mismatch("byte_count", want.byte_count, rsp_data.byte_count);
            if (rsp_data.image_end !== want.image_end)
               report_mismatch("image_end", want.image_end, rsp_data.image_end);
            if (rsp_data.end_cause !== want.end_cause)
               report_mismatch("end_cause", want.end_cause, rsp_data.end_cause);
         end
      end
   end

   function automatic void clear_image_state();
      parse_st  = PH_COUNT;
      run_len   = '0;
      lit_left  = '0;
      pad_due   = 1'b0;
      line_ofs  = '0;
      out_total = '0;
      img_over  = 1'b0;
   endfunction

   // Decode one compressed byte; leave the words it causes in fresh_words.
   function automatic void decode_byte(input req_type item, output bit ignored);
      logic [7:0] run_bytes[$];
      logic [7:0] code;
      logic [1:0] pad_len;
      logic [1:0] cause;
      bit         ended;
      bit         done_cmd;
      int         n_words;
      int         cnt;
      int         base;
      rsp_type    w;

      fresh_words.delete();
      code     = item.code_byte;
      ended    = 1'b0;
      done_cmd = 1'b0;
      cause    = CAUSE_END_CODE;
      ignored  = 1'b0;

      // Drop everything after an image end until the byte flagged last.
      if (img_over) begin
         ignored = 1'b1;
         if (item.last_byte)
            clear_image_state();
         return;
      end

      case (parse_st)
         PH_SECOND: begin
            if (run_len != 0) begin
               repeat (run_len) run_bytes.push_back(code);
               line_ofs = line_ofs + run_len[1:0];
               done_cmd = 1'b1;
            end else if (code > ESC_DELTA) begin
               lit_left = code;
               pad_due  = code[0];
               parse_st = PH_LITERAL;
            end else if (code == ESC_EOL) begin
               pad_len = 2'd0 - line_ofs;
               repeat (pad_len) run_bytes.push_back(8'd0);
               line_ofs = '0;
               done_cmd = 1'b1;
            end else if (code == ESC_EOI) begin
               ended = 1'b1;
               cause = CAUSE_END_CODE;
            end else begin
               done_cmd = 1'b1;
            end
         end
         PH_LITERAL: begin
            run_bytes.push_back(code);
            line_ofs = line_ofs + 2'd1;
            if (lit_left > 0)
               lit_left = lit_left - 8'd1;
            if (lit_left == 0) begin
               if (pad_due)
                  parse_st = PH_PAD;
               else
                  done_cmd = 1'b1;
            end
         end
         PH_PAD: begin
            done_cmd = 1'b1;
         end
         default: begin
            // At a command boundary a full output ends the image unparsed.
            if (out_total >= cap_limit) begin
               ended = 1'b1;
               cause = CAUSE_CAPACITY;
            end else begin
               run_len  = code;
               parse_st = PH_SECOND;
            end
         end
      endcase

      if (done_cmd) begin
         parse_st = PH_COUNT;
         run_len  = '0;
         lit_left = '0;
         pad_due  = 1'b0;
      end

      if (BW_MAX - out_total < run_bytes.size())
         out_total = BW_MAX;
      else
         out_total = out_total + CAP_W'(run_bytes.size());

      // End code beats capacity, capacity beats source exhausted.
      if (done_cmd && !ended && out_total >= cap_limit) begin
         ended = 1'b1;
         cause = CAUSE_CAPACITY;
      end
      if (!ended && item.last_byte) begin
         ended = 1'b1;
         cause = CAUSE_SOURCE;
      end

      if (run_bytes.size() == 0)
         n_words = ended ? 1 : 0;
      else
         n_words = (run_bytes.size() + LANES - 1) / LANES;
      if (n_words > MAX_WORDS)
         n_words = MAX_WORDS;

      for (int k = 0; k < n_words; k++) begin
         w    = '0;
         base = k * LANES;
         cnt  = (base < run_bytes.size()) ? run_bytes.size() - base : 0;
         if (cnt > LANES)
            cnt = LANES;
         for (int i = 0; i < cnt; i++)
            w.pixel_bytes[8*i +: 8] = run_bytes[base + i];
         w.byte_count = 4'(cnt);
         if (ended && k == n_words - 1) begin
            w.image_end = 1'b1;
            w.end_cause = cause;
         end
         fresh_words.push_back(w);
      end

      if (ended) begin
         if (item.last_byte)
            clear_image_state();
         else
            img_over = 1'b1;
      end
   endfunction

   // Offer one byte after a random gap, hold it until the transfer, then
   // queue what it should produce (a typed-in word replaces the prediction).
   task automatic send_byte(input logic [7:0] code, input logic last, input bit typed,
                            input rsp_type want);
      req_type item;
      bit      ignored;
      item.code_byte = code;
      item.last_byte = last;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(item, ignored);
      if (!ignored)
         counted++;
      if (typed)
         pending_words.push_back(want);
      else
         foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
   endtask

   // Drop valid, wait out every expected word, then let the block finish
   // any byte that causes no word.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      settle_block();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cap_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_byte(input logic [7:0] code, input logic last);
      stim_row_type row;
      row.kind  = ROW_BYTE;
      row.value = CAP_W'(code);
      row.last  = last;
      row.typed = 1'b0;
      row.want  = '0;
      stim_rows.push_back(row);
   endtask

   task automatic add_end(input logic [7:0] code, input logic last, input logic [63:0] word,
                          input logic [3:0] cnt, input logic [1:0] cause);
      stim_row_type row;
      row.kind                 = ROW_BYTE;
      row.value                = CAP_W'(code);
      row.last                 = last;
      row.typed                = 1'b1;
      row.want.pixel_bytes     = word;
      row.want.byte_count      = cnt;
      row.want.image_end       = 1'b1;
      row.want.end_cause       = cause;
      stim_rows.push_back(row);
   endtask

   task automatic add_cap(input logic [CAP_W-1:0] value);
      stim_row_type row;
      row.kind  = ROW_CAPACITY;
      row.value = value;
      row.last  = 1'b0;
      row.typed = 1'b0;
      row.want  = '0;
      stim_rows.push_back(row);
   endtask

   // Build one image: mostly well-formed commands with random content, some
   // stray bytes, and an ending by end code, by running dry or mid-command.
   task automatic send_image();
      logic [7:0] img[$];
      int         len;
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 11))
            0, 1, 2, 3: begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 255)
                                                 : $urandom_range(1, 12);
               img.push_back(8'(len));
               img.push_back(8'($urandom_range(255)));
            end
            4, 5, 6: begin
               len = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 255)
                                                  : $urandom_range(3, 10);
               img.push_back(ESCAPE);
               img.push_back(8'(len));
               repeat (len) img.push_back(8'($urandom_range(255)));
               if (len % 2 == 1)
                  img.push_back(8'($urandom_range(255)));
            end
            7, 8: begin
               img.push_back(ESCAPE);
               img.push_back(ESC_EOL);
            end
            9: begin
               img.push_back(ESCAPE);
               img.push_back(ESC_DELTA);
            end
            default: begin
               img.push_back(8'($urandom_range(255)));
            end
         endcase
      end
      case ($urandom_range(0, 3))
         0, 1: begin
            img.push_back(ESCAPE);
            img.push_back(ESC_EOI);
            repeat ($urandom_range(0, 2)) img.push_back(8'($urandom_range(255)));
         end
         2: ;
         default: img.push_back(8'($urandom_range(255)));
      endcase
      foreach (img[i])
         send_byte(img[i], (i == img.size() - 1), 1'b0, '0);
   endtask

   initial begin
      clear_image_state();
      cap_limit = CAP_RESET;

      // Directed rows, first at the reset capacity.
      add_byte(ESCAPE, 1'b0);
      add_end(ESC_EOI, 1'b0, '0, 4'd0, CAUSE_END_CODE);
      add_byte(8'hAB, 1'b1);                       // ignored, readies next image
      add_byte(8'hFF, 1'b0);                       // longest fill, all ones
      add_byte(8'hFF, 1'b0);
      add_byte(ESCAPE, 1'b0);                      // odd literal with pad
      add_byte(8'd3, 1'b0);
      add_byte(8'h12, 1'b0);
      add_byte(8'h34, 1'b0);
      add_byte(8'h56, 1'b0);
      add_byte(8'hEE, 1'b0);
      add_byte(ESCAPE, 1'b0);
      add_byte(ESC_DELTA, 1'b0);
      add_byte(8'd3, 1'b0);
      add_byte(8'h77, 1'b0);
      add_byte(ESCAPE, 1'b0);                      // end of line pads with zeros
      add_byte(ESC_EOL, 1'b0);
      add_end(8'd5, 1'b1, '0, 4'd0, CAUSE_SOURCE); // last byte inside a command
      add_byte(ESCAPE, 1'b0);
      add_end(ESC_EOI, 1'b1, '0, 4'd0, CAUSE_END_CODE);
      add_cap('0);                                 // full before the first command
      add_end(8'h10, 1'b0, '0, 4'd0, CAUSE_CAPACITY);
      add_byte(8'h33, 1'b1);
      add_cap(31'd1);                              // overrun, capacity beats last
      add_byte(8'd4, 1'b0);
      add_end(8'h5A, 1'b1, 64'h5A5A_5A5A, 4'd4, CAUSE_CAPACITY);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) begin
         if (stim_rows[r].kind == ROW_CAPACITY)
            write_capacity(stim_rows[r].value);
         else
            send_byte(stim_rows[r].value[7:0], stim_rows[r].last, stim_rows[r].typed,
                      stim_rows[r].want);
      end

      // Random images in three idling patterns, each with its own capacity.
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               tx_idle_pct = 12;
               rx_idle_pct = 48;
               write_capacity(CAP_W'($urandom_range(16, 96)));
            end
            1: begin
               tx_idle_pct = 48;
               rx_idle_pct = 12;
               write_capacity(CAP_ALL_LOW);
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               write_capacity(CAP_RESET);
            end
         endcase
         counted = 0;
         while (counted < PHASE_ITEMS) send_image();
      end

      settle_block();
      if (mismatches == 0 && pending_words.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
